// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FFRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffrp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FFRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffrp assertion failed");

`endif

// ===== sv/ffrp_pkg.sv =====
package ffrp_pkg;

  localparam int GRID_SIZE_DEF = 16;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int DIM_W     = 4;
  localparam int ID_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] GRID_COLS_RST = 5'd6;
  localparam logic [CFG_W-1:0] GRID_ROWS_RST = 5'd6;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [ID_W-1:0] ID_FIRST = 8'd1;
  localparam logic [ID_W-1:0] ID_MAX   = 8'd255;

endpackage

// ===== sv/ffrp_if.sv =====
interface ffrp_in_if import ffrp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             op;
  logic [DIM_W-1:0] box_width;
  logic [DIM_W-1:0] box_height;

  modport source (output valid, output op, output box_width, output box_height,
                  input ready);
  modport sink (input valid, input op, input box_width, input box_height,
                output ready);
endinterface

interface ffrp_out_if import ffrp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             placed;
  logic [DIM_W-1:0] x_start;
  logic [DIM_W-1:0] y_start;
  logic [ID_W-1:0]  box_id;

  modport source (output valid, output placed, output x_start, output y_start,
                  output box_id, input ready);
  modport sink (input valid, input placed, input x_start, input y_start,
                input box_id, output ready);
endinterface

interface ffrp_cfg_if import ffrp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ffrp_ram.sv =====
module ffrp_ram import ffrp_pkg::*; #(
  parameter int WIDTH = GRID_SIZE_DEF,
  parameter int DEPTH = GRID_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/first_fit_rectangle_placer.sv =====
// channel  dir  beat fields
// -------  ---  ------------------------------------------
// in_ch    in   op, box_width, box_height
// out_ch   out  placed, x_start, y_start, box_id
// cfg_ch   in   index (0 grid_cols, 1 grid_rows), data
//
// Clear empties the grid, restarts box ids and goes straight to its result. Place
// ORs the covered columns (registered read) for each candidate column, tests the
// rows in turn against them, and on a fit reads and marks the covered columns.
// Reset (synchronous, rst_n low) clears the per-column valid bits at once.
// in_ch is ready only between items; a stalled out_ch holds its beat while
// the next item runs up to its result.
module first_fit_rectangle_placer import ffrp_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ffrp_in_if.sink   in_ch,
  ffrp_out_if.source out_ch,
  ffrp_cfg_if.sink  cfg_ch
);

  localparam int IW = $clog2(GRID_SIZE);
  localparam int EW = $clog2(GRID_SIZE + 1);
  localparam int SW = ((EW > CFG_W) ? EW : CFG_W) + 1;
  localparam logic [SW-1:0] GRID_EXT = SW'(GRID_SIZE);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_XCHK = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_YCHK = 8'b0001_0000,
    S_MRD  = 8'b0010_0000,
    S_MWR  = 8'b0100_0000,
    S_PUSH = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     cols_cfg_r, cols_cfg_nxt;
  logic [CFG_W-1:0]     rows_cfg_r, rows_cfg_nxt;
  logic [SW-1:0]        cols_r, cols_nxt;
  logic [SW-1:0]        rows_r, rows_nxt;
  logic [DIM_W-1:0]     w_r, w_nxt;
  logic [DIM_W-1:0]     h_r, h_nxt;
  logic [EW-1:0]        x_r, x_nxt;
  logic [EW-1:0]        y_r, y_nxt;
  logic [IW-1:0]        c_r, c_nxt;
  logic [GRID_SIZE-1:0] acc_r, acc_nxt;
  logic [GRID_SIZE-1:0] col_vld_r, col_vld_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [ID_W-1:0]      next_id_r, next_id_nxt;
  logic                 res_placed_r, res_placed_nxt;
  logic [DIM_W-1:0]     res_x_r, res_x_nxt;
  logic [DIM_W-1:0]     res_y_r, res_y_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_placed_r, out_placed_nxt;
  logic [DIM_W-1:0]     out_x_r, out_x_nxt;
  logic [DIM_W-1:0]     out_y_r, out_y_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;

  logic [SW-1:0]        x_end;
  logic [SW-1:0]        y_end;
  logic                 c_last;
  logic [GRID_SIZE-1:0] hmask;
  logic [GRID_SIZE-1:0] win;
  logic [GRID_SIZE-1:0] ram_rdata;
  logic [GRID_SIZE-1:0] col_data;
  logic                 ram_re;
  logic                 ram_we;

  ffrp_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_col_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(c_r),
    .wdata(col_data | win),
    .re   (ram_re),
    .raddr(c_r),
    .rdata(ram_rdata)
  );

  assign in_ch.ready    = (state_r == S_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.placed  = out_placed_r;
  assign out_ch.x_start = out_x_r;
  assign out_ch.y_start = out_y_r;
  assign out_ch.box_id  = out_id_r;

  assign x_end    = SW'(x_r) + SW'(w_r);
  assign y_end    = SW'(y_r) + SW'(h_r);
  assign c_last   = (SW'(c_r) == x_end);
  assign col_data = rd_vld_r ? ram_rdata : '0;
  assign win      = hmask << y_r;
  assign ram_re   = (state_r == S_RD) || (state_r == S_MRD);
  assign ram_we   = (state_r == S_MWR);

  always_comb begin
    for (int i = 0; i < GRID_SIZE; i++) begin
      hmask[i] = (SW'(i) <= SW'(h_r));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cols_cfg_nxt   = cols_cfg_r;
    rows_cfg_nxt   = rows_cfg_r;
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    c_nxt          = c_r;
    acc_nxt        = acc_r;
    col_vld_nxt    = col_vld_r;
    rd_vld_nxt     = rd_vld_r;
    next_id_nxt    = next_id_r;
    res_placed_nxt = res_placed_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_id_nxt     = res_id_r;
    out_vld_nxt    = out_vld_r;
    out_placed_nxt = out_placed_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_id_nxt     = out_id_r;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GRID_COLS: cols_cfg_nxt = cfg_ch.data;
        REG_GRID_ROWS: rows_cfg_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    if (ram_re) begin
      rd_vld_nxt = col_vld_r[c_r];
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          w_nxt          = in_ch.box_width;
          h_nxt          = in_ch.box_height;
          cols_nxt       = (SW'(cols_cfg_r) > GRID_EXT) ? GRID_EXT : SW'(cols_cfg_r);
          rows_nxt       = (SW'(rows_cfg_r) > GRID_EXT) ? GRID_EXT : SW'(rows_cfg_r);
          x_nxt          = '0;
          res_placed_nxt = 1'b0;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
          res_id_nxt     = '0;
          if (in_ch.op == OP_CLEAR) begin
            col_vld_nxt = '0;
            next_id_nxt = ID_FIRST;
            state_nxt   = S_PUSH;
          end else begin
            res_id_nxt = next_id_r;
            if (next_id_r != ID_MAX) begin
              next_id_nxt = next_id_r + 1'b1;
            end
            state_nxt = S_XCHK;
          end
        end
      end
      S_XCHK: begin
        if ((x_end < cols_r) && (SW'(h_r) < rows_r)) begin
          acc_nxt   = '0;
          c_nxt     = x_r[IW-1:0];
          state_nxt = S_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r | col_data;
        if (c_last) begin
          y_nxt     = '0;
          state_nxt = S_YCHK;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_YCHK: begin
        if (y_end >= rows_r) begin
          x_nxt     = x_r + 1'b1;
          state_nxt = S_XCHK;
        end else if ((acc_r & win) == '0) begin
          c_nxt          = x_r[IW-1:0];
          res_placed_nxt = 1'b1;
          res_x_nxt      = DIM_W'(x_r);
          res_y_nxt      = DIM_W'(y_r);
          state_nxt      = S_MRD;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        col_vld_nxt[c_r] = 1'b1;
        if (c_last) begin
          state_nxt = S_PUSH;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_MRD;
        end
      end
      S_PUSH: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt    = 1'b1;
          out_placed_nxt = res_placed_r;
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cols_cfg_r <= GRID_COLS_RST;
      rows_cfg_r <= GRID_ROWS_RST;
      col_vld_r  <= '0;
      rd_vld_r   <= 1'b0;
      next_id_r  <= ID_FIRST;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      rows_cfg_r <= rows_cfg_nxt;
      col_vld_r  <= col_vld_nxt;
      rd_vld_r   <= rd_vld_nxt;
      next_id_r  <= next_id_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cols_r       <= cols_nxt;
    rows_r       <= rows_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    c_r          <= c_nxt;
    acc_r        <= acc_nxt;
    res_placed_r <= res_placed_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_id_r     <= res_id_nxt;
    out_placed_r <= out_placed_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule

// ===== sv/ffrp_chk.sv =====
`include "assert_macros.svh"

module ffrp_chk import ffrp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_placed,
  input logic [DIM_W-1:0] out_x_start,
  input logic [DIM_W-1:0] out_y_start,
  input logic [ID_W-1:0]  out_box_id,
  input logic             cfg_ready
);

  `FFRP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `FFRP_ASSERT_NOW(a_unplaced_at_origin, out_valid && !out_placed, (out_x_start == '0) && (out_y_start == '0))
  `FFRP_ASSERT_NOW(a_placed_has_id, out_valid && out_placed, out_box_id != '0)
  `FFRP_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)
  `FFRP_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)

endmodule

bind first_fit_rectangle_placer ffrp_chk u_ffrp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_placed (out_ch.placed),
  .out_x_start(out_ch.x_start),
  .out_y_start(out_ch.y_start),
  .out_box_id (out_ch.box_id),
  .cfg_ready  (cfg_ch.ready)
);
